FILE: sv/mrs_pkg.sv
// Shared types, protocol codes and the CRC-16 step for the single-register Modbus RTU slave.
`timescale 1ns / 1ps
`default_nettype none

package mrs_pkg;

    // Frame and CRC
    localparam int unsigned FRAME_LEN = 8;
    localparam logic [2:0] POS_LAST = 3'(FRAME_LEN - 1);
    localparam logic [2:0] POS_CRC_END = 3'(FRAME_LEN - 2);
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0] DEV_ADDR_RESET = 8'd1;

    // Function codes
    localparam logic [7:0] FC_MODE_OP = 8'd1;
    localparam logic [7:0] FC_MODE_STOP = 8'd2;
    localparam logic [7:0] FC_READ = 8'd3;
    localparam logic [7:0] FC_WRITE = 8'd6;
    localparam logic [7:0] FC_MODE_PREOP = 8'd80;
    localparam logic [7:0] FC_MODE_RESET = 8'd81;
    localparam logic [7:0] FC_NOP = 8'd82;

    // Exception responses: function byte, then error code
    localparam logic [7:0] EXC_GENERIC = 8'h80;
    localparam logic [7:0] EXC_READ = 8'h83;
    localparam logic [7:0] EXC_WRITE = 8'h86;
    localparam logic [7:0] ERR_ILLEGAL_FUNC = 8'h01;
    localparam logic [7:0] ERR_ILLEGAL_ADDR = 8'h02;
    localparam logic [7:0] ERR_ILLEGAL_VALUE = 8'h03;

    // Holding register address and write values
    localparam logic [15:0] HOLD_REG_ADDR = 16'd1;
    localparam logic [15:0] READ_COUNT = 16'd1;
    localparam logic [15:0] WR_VAL_SET = 16'd1;
    localparam logic [15:0] WR_VAL_CLEAR = 16'd2;
    localparam logic [7:0] READ_BYTE_COUNT = 8'd2;

    // Mode commands
    typedef enum logic [2:0] {
        MODE_NONE        = 3'd0,
        MODE_OPERATIONAL = 3'd1,
        MODE_STOP        = 3'd2,
        MODE_PREOP       = 3'd3,
        MODE_RESET       = 3'd4
    } mode_t;

    // One response job handed from the frame decoder to the transmitter
    typedef struct packed {
        logic [5:0][7:0] bytes;    // body bytes, entry 0 goes first
        logic [2:0]      count;    // body beats before the CRC
        logic            crc_en;   // append CRC high then low
        logic            cmd_only; // single beat carrying only a mode command
        mode_t           mode;
        logic            led;
    } job_t;

    // One byte through the reflected CRC-16
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: sv/mrs_rx.sv
// Request frame capture, running CRC and frame decode into a response job.
`timescale 1ns / 1ps
`default_nettype none

module mrs_rx (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [7:0]    rx_byte,
    input  wire logic [7:0]    device_address,
    input  wire logic          tx_busy,
    output logic               in_stall,
    output logic               job_load,
    output mrs_pkg::job_t      job
);

    logic [2:0]       pos_reg;
    logic [2:0]       pos_next;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic             bit_reg;
    logic             bit_next;
    logic [7:0]       store_reg [7];
    logic             accept;
    logic             judge;
    logic             emit;
    logic [15:0]      rx_crc;
    logic [15:0]      reg_addr;
    logic [15:0]      reg_val;
    mrs_pkg::job_t    job_c;

    // Last byte of a frame waits while the transmitter is still busy with the previous response
    assign in_stall = (pos_reg == mrs_pkg::POS_LAST) && tx_busy;
    assign accept   = in_valid && !in_stall;
    assign judge    = accept && (pos_reg == mrs_pkg::POS_LAST);

    // Byte position and running CRC
    always_comb
    begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        if (accept)
        begin
            if (judge)
            begin
                pos_next = '0;
                crc_next = mrs_pkg::CRC_INIT;
            end
            else
            begin
                pos_next = pos_reg + 3'd1;
                if (pos_reg < mrs_pkg::POS_CRC_END)
                    crc_next = mrs_pkg::crc_feed(crc_reg, rx_byte);
            end
        end
    end

    // Frame decode on the last byte
    assign rx_crc   = {store_reg[6], rx_byte};
    assign reg_addr = {store_reg[2], store_reg[3]};
    assign reg_val  = {store_reg[4], store_reg[5]};

    always_comb
    begin
        job_c          = '0;
        job_c.mode     = mrs_pkg::MODE_NONE;
        emit           = 1'b0;
        bit_next       = bit_reg;
        if (store_reg[0] == device_address)
        begin
            emit        = 1'b1;
            job_c.count = 3'd2;
            if (rx_crc != crc_reg)
            begin
                job_c.bytes[0] = mrs_pkg::EXC_GENERIC;
                job_c.bytes[1] = mrs_pkg::ERR_ILLEGAL_VALUE;
            end
            else
            begin
                case (store_reg[1])
                    mrs_pkg::FC_READ:
                    begin
                        if (reg_addr == mrs_pkg::HOLD_REG_ADDR && reg_val == mrs_pkg::READ_COUNT)
                        begin
                            job_c.bytes[0] = device_address;
                            job_c.bytes[1] = mrs_pkg::FC_READ;
                            job_c.bytes[2] = mrs_pkg::READ_BYTE_COUNT;
                            job_c.bytes[3] = 8'h00;
                            job_c.bytes[4] = {7'd0, bit_reg};
                            job_c.count    = 3'd5;
                            job_c.crc_en   = 1'b1;
                        end
                        else
                        begin
                            job_c.bytes[0] = mrs_pkg::EXC_READ;
                            job_c.bytes[1] = mrs_pkg::ERR_ILLEGAL_ADDR;
                        end
                    end
                    mrs_pkg::FC_WRITE:
                    begin
                        if (reg_addr != mrs_pkg::HOLD_REG_ADDR)
                        begin
                            job_c.bytes[0] = mrs_pkg::EXC_WRITE;
                            job_c.bytes[1] = mrs_pkg::ERR_ILLEGAL_ADDR;
                        end
                        else if (reg_val != mrs_pkg::WR_VAL_SET &&
                                 reg_val != mrs_pkg::WR_VAL_CLEAR)
                        begin
                            job_c.bytes[0] = mrs_pkg::EXC_WRITE;
                            job_c.bytes[1] = mrs_pkg::ERR_ILLEGAL_VALUE;
                        end
                        else
                        begin
                            bit_next       = (reg_val == mrs_pkg::WR_VAL_SET);
                            job_c.bytes[0] = device_address;
                            job_c.bytes[1] = mrs_pkg::FC_WRITE;
                            job_c.bytes[2] = store_reg[2];
                            job_c.bytes[3] = store_reg[3];
                            job_c.bytes[4] = 8'h00;
                            job_c.bytes[5] = {7'd0, bit_next};
                            job_c.count    = 3'd6;
                            job_c.crc_en   = 1'b1;
                        end
                    end
                    mrs_pkg::FC_MODE_OP,
                    mrs_pkg::FC_MODE_STOP,
                    mrs_pkg::FC_MODE_PREOP,
                    mrs_pkg::FC_MODE_RESET:
                    begin
                        job_c.count    = 3'd1;
                        job_c.cmd_only = 1'b1;
                        if (store_reg[1] == mrs_pkg::FC_MODE_OP)
                            job_c.mode = mrs_pkg::MODE_OPERATIONAL;
                        else if (store_reg[1] == mrs_pkg::FC_MODE_STOP)
                            job_c.mode = mrs_pkg::MODE_STOP;
                        else if (store_reg[1] == mrs_pkg::FC_MODE_PREOP)
                            job_c.mode = mrs_pkg::MODE_PREOP;
                        else
                            job_c.mode = mrs_pkg::MODE_RESET;
                    end
                    mrs_pkg::FC_NOP:
                    begin
                        emit = 1'b0;
                    end
                    default:
                    begin
                        job_c.bytes[0] = mrs_pkg::EXC_GENERIC;
                        job_c.bytes[1] = mrs_pkg::ERR_ILLEGAL_FUNC;
                    end
                endcase
            end
        end
        job_c.led = bit_next;
    end

    assign job      = job_c;
    assign job_load = judge && emit;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            crc_reg <= mrs_pkg::CRC_INIT;
            bit_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            if (judge)
                bit_reg <= bit_next;
        end
    end

    // Frame bytes 0 to 6
    always_ff @(posedge clk)
    begin
        if (accept && !judge)
            store_reg[pos_reg] <= rx_byte;
    end

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        job_load |-> !tx_busy)
        else $error("job loaded while transmitter busy");
    a_bit_only_on_judge: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(bit_reg) |-> $past(judge))
        else $error("register bit changed outside frame end");
    a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
        judge |=> (pos_reg == 3'd0) && (crc_reg == mrs_pkg::CRC_INIT))
        else $error("frame state not restarted after last byte");
`endif

endmodule

`default_nettype wire

FILE: sv/mrs_tx.sv
// Response transmitter: walks a job beat by beat, appends the CRC when the job asks, holds an output register.
`timescale 1ns / 1ps
`default_nettype none

module mrs_tx (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_load,
    input  wire mrs_pkg::job_t job,
    output logic               busy,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         resp_byte,
    output logic               resp_valid,
    output logic               resp_last,
    output logic [2:0]         mode_command,
    output logic               led_level
);

    logic             busy_reg;
    logic [2:0]       idx_reg;
    logic [15:0]      crc_reg;
    mrs_pkg::job_t    job_reg;
    logic             out_valid_reg;
    logic [7:0]       byte_reg;
    logic             valid_bit_reg;
    logic             last_reg;
    logic [2:0]       mode_reg;
    logic             led_reg;
    logic             advance;
    logic [3:0]       total;
    logic             beat_last;
    logic             in_body;
    logic [7:0]       beat_byte;

    // Next beat when the output register is empty or being taken
    assign advance   = busy_reg && (!out_valid_reg || !out_stall);
    assign total     = {1'b0, job_reg.count} + (job_reg.crc_en ? 4'd2 : 4'd0);
    assign beat_last = ({1'b0, idx_reg} + 4'd1) == total;
    assign in_body   = idx_reg < job_reg.count;

    // Beat byte: body, then CRC high, then CRC low
    always_comb
    begin
        if (in_body)
        begin
            case (idx_reg)
                3'd0:    beat_byte = job_reg.bytes[0];
                3'd1:    beat_byte = job_reg.bytes[1];
                3'd2:    beat_byte = job_reg.bytes[2];
                3'd3:    beat_byte = job_reg.bytes[3];
                3'd4:    beat_byte = job_reg.bytes[4];
                3'd5:    beat_byte = job_reg.bytes[5];
                default: beat_byte = 8'h00;
            endcase
        end
        else if (idx_reg == job_reg.count)
            beat_byte = crc_reg[15:8];
        else
            beat_byte = crc_reg[7:0];
    end

    // Sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_load)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (advance)
            begin
                idx_reg <= idx_reg + 3'd1;
                if (beat_last)
                    busy_reg <= 1'b0;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Job, CRC and output payload
    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_reg <= job;
            crc_reg <= mrs_pkg::CRC_INIT;
        end
        else if (advance && in_body)
            crc_reg <= mrs_pkg::crc_feed(crc_reg, beat_byte);
        if (advance)
        begin
            byte_reg      <= beat_byte;
            valid_bit_reg <= !job_reg.cmd_only;
            last_reg      <= beat_last;
            mode_reg      <= job_reg.mode;
            led_reg       <= job_reg.led;
        end
    end

    assign busy         = busy_reg;
    assign out_valid    = out_valid_reg;
    assign resp_byte    = byte_reg;
    assign resp_valid   = valid_bit_reg;
    assign resp_last    = last_reg;
    assign mode_command = mode_reg;
    assign led_level    = led_reg;

`ifndef SYNTHESIS
    a_busy_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> $past(job_load))
        else $error("transmitter busy without a job");
    a_cmd_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !valid_bit_reg) |-> last_reg)
        else $error("command-only beat not marked last");
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && beat_last) |=> (!busy_reg || $past(job_load)))
        else $error("transmitter still busy after last beat");
`endif

endmodule

`default_nettype wire

FILE: sv/modbus_rtu_slave_single_register_core.sv
// Top level of the single-register Modbus RTU slave.
//
// Input channel: one request byte per beat on rx_byte (in_valid / in_stall).
// Request frames are a fixed eight bytes; the block counts them itself.
// Output channel: one result per beat (out_valid / out_stall) carrying
// resp_byte, resp_valid (0 on a command-only result), resp_last on the final
// result of a frame, mode_command and led_level.
// Configuration: cfg_write with cfg_data loads the slave address.
// Throughput: one request byte per cycle. Bytes 0 to 6 of a frame never stall;
// the last byte of a frame waits until the previous frame's final beat has
// moved into the output register (up to 8 beats, one per cycle while the receiver
// does not stall). Latency: the last frame byte loads the job into the
// transmitter, whose sequencer then registers the first result into the output
// register; the response CRC is built one byte per beat.
// Reset: frame position and CRC restart, LED bit clears, address returns to 1,
// output is empty. When the receiver stalls, the output beat holds and the
// block keeps taking request bytes up to the next frame end.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_slave_single_register_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      resp_byte,
    output logic            resp_valid,
    output logic            resp_last,
    output logic [2:0]      mode_command,
    output logic            led_level,
    input  wire logic       cfg_write,
    input  wire logic [7:0] cfg_data
);

    logic [7:0]       dev_addr_reg;
    logic             tx_busy;
    logic             job_load;
    mrs_pkg::job_t    job;

    // Slave address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dev_addr_reg <= mrs_pkg::DEV_ADDR_RESET;
        else if (cfg_write)
            dev_addr_reg <= cfg_data;
    end

    // Frame capture and decode
    mrs_rx u_rx (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .rx_byte        (rx_byte),
        .device_address (dev_addr_reg),
        .tx_busy        (tx_busy),
        .in_stall       (in_stall),
        .job_load       (job_load),
        .job            (job)
    );

    // Response transmitter
    mrs_tx u_tx (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_load     (job_load),
        .job          (job),
        .busy         (tx_busy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .resp_byte    (resp_byte),
        .resp_valid   (resp_valid),
        .resp_last    (resp_last),
        .mode_command (mode_command),
        .led_level    (led_level)
    );

`ifndef SYNTHESIS
    a_stall_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> tx_busy)
        else $error("input stalled with idle transmitter");
    a_no_load_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> !job_load)
        else $error("job loaded on a stalled byte");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(resp_byte) &&
            $stable(resp_valid) && $stable(resp_last) &&
            $stable(mode_command) && $stable(led_level))
        else $error("output beat changed while stalled");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_modbus_rtu_slave_single_register_core.sv
// Self-checking testbench for the single-register Modbus RTU slave core.
`timescale 1ns / 1ps

module tb_modbus_rtu_slave_single_register_core;

    import mrs_pkg::*;

    localparam int SETTLE_CYCLES = 12;   // one full response plus margin
    localparam int LONG_HOLD = 120;
    localparam int RANDOM_FRAMES = 4;
    localparam int TAIL_FRAMES = 2;
    localparam longint TIMEOUT_NS = 5_000_000;

    typedef logic [0:7][7:0] frame_t;

    // One response beat as the block should present it
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        mode_t      mode;
        logic       led;
    } resp_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] resp_byte;
    logic       resp_valid;
    logic       resp_last;
    logic [2:0] mode_command;
    logic       led_level;
    logic       cfg_write = 1'b0;
    logic [7:0] cfg_data = 8'h00;

    // Idling control
    logic calm = 1'b0;
    logic hold_flip = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;
    int   stall_left = 0;

    // Slave state as predicted
    logic [7:0]  dev_addr = DEV_ADDR_RESET;
    logic [2:0]  rx_pos = 3'd0;
    logic [7:0]  held [0:6];
    logic [15:0] rx_crc = CRC_INIT;
    logic        led_bit = 1'b0;

    resp_beat_t resp_due [$];
    int         mismatches = 0;

    modbus_rtu_slave_single_register_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .resp_byte    (resp_byte),
        .resp_valid   (resp_valid),
        .resp_last    (resp_last),
        .mode_command (mode_command),
        .led_level    (led_level),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Reflected CRC-16, one byte
    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
        logic [15:0] c;
        c = acc ^ {8'h00, data};
        repeat (8)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic void push_beat(input logic [7:0] data, input logic valid,
                                      input logic last, input mode_t mode);
        resp_due.push_back('{data: data, valid: valid, last: last, mode: mode, led: led_bit});
    endfunction

    function automatic void push_pair(input logic [7:0] fn, input logic [7:0] code);
        push_beat(fn, 1'b1, 1'b0, MODE_NONE);
        push_beat(code, 1'b1, 1'b1, MODE_NONE);
    endfunction

    // Body beats, then the CRC high byte first
    function automatic void push_packet(input logic [0:5][7:0] body, input int n);
        logic [15:0] c;
        c = CRC_INIT;
        for (int i = 0; i < n; i++) begin
            c = crc16_step(c, body[i]);
            push_beat(body[i], 1'b1, 1'b0, MODE_NONE);
        end
        push_beat(c[15:8], 1'b1, 1'b0, MODE_NONE);
        push_beat(c[7:0], 1'b1, 1'b1, MODE_NONE);
    endfunction

    // Decide the response to a complete frame
    function automatic void judge_request(input logic [7:0] crc_lo);
        logic [15:0] reg_addr;
        logic [15:0] reg_val;
        if (held[0] != dev_addr)
            return;
        if ({held[6], crc_lo} != rx_crc) begin
            push_pair(EXC_GENERIC, ERR_ILLEGAL_VALUE);  // CRC error reply
            return;
        end
        reg_addr = {held[2], held[3]};
        reg_val = {held[4], held[5]};
        case (held[1])
            FC_READ:
                if (reg_addr == HOLD_REG_ADDR && reg_val == READ_COUNT)
                    push_packet({dev_addr, FC_READ, READ_BYTE_COUNT, 8'h00,
                                 {7'd0, led_bit}, 8'h00}, 5);
                else
                    push_pair(EXC_READ, ERR_ILLEGAL_ADDR);
            FC_WRITE:
                if (reg_addr != HOLD_REG_ADDR)
                    push_pair(EXC_WRITE, ERR_ILLEGAL_ADDR);
                else if (reg_val != WR_VAL_SET && reg_val != WR_VAL_CLEAR)
                    push_pair(EXC_WRITE, ERR_ILLEGAL_VALUE);
                else begin
                    led_bit = (reg_val == WR_VAL_SET);
                    push_packet({dev_addr, FC_WRITE, held[2], held[3], 8'h00,
                                 {7'd0, led_bit}}, 6);
                end
            FC_MODE_OP:    push_beat(8'h00, 1'b0, 1'b1, MODE_OPERATIONAL);
            FC_MODE_STOP:  push_beat(8'h00, 1'b0, 1'b1, MODE_STOP);
            FC_MODE_PREOP: push_beat(8'h00, 1'b0, 1'b1, MODE_PREOP);
            FC_MODE_RESET: push_beat(8'h00, 1'b0, 1'b1, MODE_RESET);
            FC_NOP: ;
            default:       push_pair(EXC_GENERIC, ERR_ILLEGAL_FUNC);
        endcase
    endfunction

    // Advance the predicted receiver by one accepted request byte
    function automatic void track_request_byte(input logic [7:0] data);
        if (rx_pos != POS_LAST) begin
            held[rx_pos] = data;
            if (rx_pos < POS_CRC_END)
                rx_crc = crc16_step(rx_crc, data);
            rx_pos = rx_pos + 3'd1;
        end else begin
            judge_request(data);
            rx_pos = 3'd0;
            rx_crc = CRC_INIT;
        end
    endfunction

    function automatic frame_t make_frame(input logic [7:0] addr, input logic [7:0] fn,
                                          input logic [15:0] reg_addr,
                                          input logic [15:0] reg_val);
        frame_t f;
        logic [15:0] c;
        f[0:5] = {addr, fn, reg_addr, reg_val};
        c = CRC_INIT;
        for (int i = 0; i < 6; i++)
            c = crc16_step(c, f[i]);
        f[6] = c[15:8];
        f[7] = c[7:0];
        return f;
    endfunction

    // Mostly well-formed requests with random content, some noise and broken CRCs
    function automatic frame_t random_frame();
        frame_t f;
        logic [7:0] addr;
        logic [7:0] fn;
        logic [15:0] reg_addr;
        logic [15:0] reg_val;
        if ($urandom_range(0, 9) == 0) begin
            for (int i = 0; i < 8; i++)
                f[i] = 8'($urandom);
            return f;
        end
        addr = ($urandom_range(0, 9) == 0) ? 8'($urandom) : dev_addr;
        case ($urandom_range(0, 9))
            0, 1, 2: fn = FC_READ;
            3, 4, 5: fn = FC_WRITE;
            6: case ($urandom_range(0, 3))
                   0: fn = FC_MODE_OP;
                   1: fn = FC_MODE_STOP;
                   2: fn = FC_MODE_PREOP;
                   default: fn = FC_MODE_RESET;
               endcase
            7: fn = FC_NOP;
            default: fn = 8'($urandom);
        endcase
        reg_addr = ($urandom_range(0, 4) == 0) ? 16'($urandom) : HOLD_REG_ADDR;
        case ($urandom_range(0, 5))
            0: reg_val = 16'($urandom);
            1, 2: reg_val = WR_VAL_CLEAR;
            default: reg_val = WR_VAL_SET;
        endcase
        f = make_frame(addr, fn, reg_addr, reg_val);
        if ($urandom_range(0, 9) == 0)
            f[6:7] = f[6:7] ^ 16'($urandom_range(1, 65535));
        return f;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Offer one request beat, with an occasional idle gap in front
    task automatic send_byte(input logic [7:0] data);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_request_byte(data);
    endtask

    task automatic send_frame(input frame_t f);
        for (int i = 0; i < 8; i++)
            send_byte(f[i]);
    endtask

    // Stop offering and let every predicted beat come out
    task automatic drain();
        in_valid <= 1'b0;
        while (resp_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_address(input logic [7:0] addr);
        drain();
        cfg_data <= addr;
        cfg_write <= 1'b1;
        @(posedge clk);
        dev_addr = addr;
        cfg_write <= 1'b0;
    endtask

    // Receiver: random stall bursts, plus one long hold on request
    always @(posedge clk) begin
        if (hold_flip != hold_seen) begin
            hold_seen <= hold_flip;
            hold_left <= LONG_HOLD - 1;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 6);
            out_stall <= 1'b1;
        end else
            out_stall <= 1'b0;
    end

    // Compare every accepted response beat with the oldest prediction
    always @(posedge clk) begin
        resp_beat_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (resp_due.size() == 0)
                report_mismatch($sformatf("unexpected beat, byte %02h", resp_byte));
            else begin
                want = resp_due.pop_front();
                if (resp_byte !== want.data)
                    report_mismatch($sformatf("resp_byte %02h, want %02h", resp_byte, want.data));
                if (resp_valid !== want.valid)
                    report_mismatch($sformatf("resp_valid %b, want %b", resp_valid, want.valid));
                if (resp_last !== want.last)
                    report_mismatch($sformatf("resp_last %b, want %b", resp_last, want.last));
                if (mode_command !== want.mode)
                    report_mismatch($sformatf("mode_command %0d, want %0d",
                                              mode_command, want.mode));
                if (led_level !== want.led)
                    report_mismatch($sformatf("led_level %b, want %b", led_level, want.led));
            end
        end
    end

    // Read at the reset address shows the bit cleared
    task automatic test_reset_state();
        send_frame(make_frame(DEV_ADDR_RESET, FC_READ, HOLD_REG_ADDR, READ_COUNT));
        drain();
    endtask

    task automatic test_write_read();
        send_frame(make_frame(dev_addr, FC_WRITE, HOLD_REG_ADDR, WR_VAL_SET));
        send_frame(make_frame(dev_addr, FC_READ, HOLD_REG_ADDR, READ_COUNT));
        send_frame(make_frame(dev_addr, FC_WRITE, HOLD_REG_ADDR, WR_VAL_CLEAR));
        send_frame(make_frame(dev_addr, FC_READ, HOLD_REG_ADDR, READ_COUNT));
        drain();
    endtask

    task automatic test_exceptions();
        frame_t f;
        send_frame(make_frame(dev_addr, FC_WRITE, HOLD_REG_ADDR, 16'hFFFF));
        send_frame(make_frame(dev_addr, FC_WRITE, 16'h0000, WR_VAL_SET));
        send_frame(make_frame(dev_addr, FC_READ, HOLD_REG_ADDR, 16'h0002));
        send_frame(make_frame(dev_addr, FC_READ, 16'hFFFF, READ_COUNT));
        send_frame(make_frame(dev_addr, 8'hFF, 16'hFFFF, 16'hFFFF));
        send_frame(make_frame(dev_addr, 8'h00, 16'h0000, 16'h0000));
        // broken CRC, then a frame for some other slave
        f = make_frame(dev_addr, FC_READ, HOLD_REG_ADDR, READ_COUNT);
        f[7] = ~f[7];
        send_frame(f);
        send_frame(make_frame(dev_addr + 8'd1, FC_READ, HOLD_REG_ADDR, READ_COUNT));
        drain();
    endtask

    task automatic test_mode_commands();
        send_frame(make_frame(dev_addr, FC_MODE_OP, 16'h0000, 16'h0000));
        send_frame(make_frame(dev_addr, FC_MODE_STOP, 16'h0000, 16'h0000));
        send_frame(make_frame(dev_addr, FC_MODE_PREOP, 16'h0000, 16'h0000));
        send_frame(make_frame(dev_addr, FC_MODE_RESET, 16'h0000, 16'h0000));
        send_frame(make_frame(dev_addr, FC_NOP, 16'h0000, 16'h0000));
        send_frame(make_frame(dev_addr, FC_READ, HOLD_REG_ADDR, READ_COUNT));
        drain();
    endtask

    // Extreme and out-of-range addresses, and an address change inside a frame
    task automatic test_address_config();
        frame_t f;
        write_address(8'd247);
        send_frame(make_frame(8'd247, FC_WRITE, HOLD_REG_ADDR, WR_VAL_SET));
        write_address(8'd0);
        send_frame(make_frame(8'd0, FC_READ, HOLD_REG_ADDR, READ_COUNT));
        write_address(8'd255);
        send_frame(make_frame(8'd255, FC_READ, HOLD_REG_ADDR, READ_COUNT));
        send_frame(make_frame(8'd247, FC_READ, HOLD_REG_ADDR, READ_COUNT));
        f = make_frame(8'd42, FC_WRITE, HOLD_REG_ADDR, WR_VAL_CLEAR);
        for (int i = 0; i < 4; i++)
            send_byte(f[i]);
        write_address(8'd42);
        for (int i = 4; i < 8; i++)
            send_byte(f[i]);
        write_address(DEV_ADDR_RESET);
        drain();
    endtask

    // Long receiver hold while requests keep coming; input must back up
    task automatic test_backpressure();
        hold_flip = ~hold_flip;
        send_frame(make_frame(dev_addr, FC_READ, HOLD_REG_ADDR, READ_COUNT));
        send_frame(make_frame(dev_addr, FC_WRITE, HOLD_REG_ADDR, WR_VAL_SET));
        send_frame(make_frame(dev_addr, FC_READ, HOLD_REG_ADDR, READ_COUNT));
        send_frame(make_frame(dev_addr, FC_MODE_OP, 16'h0000, 16'h0000));
        drain();
    endtask

    task automatic test_random_traffic();
        logic [7:0] addr;
        for (int n = 0; n < RANDOM_FRAMES; n++) begin
            if (n % 4 == 1) begin
                case ($urandom_range(0, 2))
                    0: addr = 8'd1;
                    1: addr = 8'd247;
                    default: addr = 8'($urandom_range(1, 247));
                endcase
                write_address(addr);
            end
            send_frame(random_frame());
        end
        drain();
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_full_rate_tail();
        calm = 1'b1;
        write_address(8'($urandom_range(1, 247)));
        for (int n = 0; n < TAIL_FRAMES; n++)
            send_frame(random_frame());
        drain();
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_write_read();
        test_exceptions();
        test_mode_commands();
        test_address_config();
        test_backpressure();
        test_random_traffic();
        test_full_rate_tail();
        if (mismatches == 0)
            $display("tb_modbus_rtu_slave_single_register_core OK");
        else
            $display("tb_modbus_rtu_slave_single_register_core NOT OK");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t ns: timeout, %0d beats still due", $time, resp_due.size());
        $display("tb_modbus_rtu_slave_single_register_core NOT OK");
        $finish;
    end

endmodule
